>>> rtl/positional_list_insert_delete_macros.svh
// Assertion macros used by the positional list sequencer.
`ifndef POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define PIL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("positional list check failed in the same cycle");

// Next-cycle implication, checked while out of reset.
`define PIL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("positional list check failed one cycle later");

`endif

>>> rtl/pil_pkg.sv
// Shared constants, codes and types of the positional list block.
package pil_pkg;

    localparam int CAPACITY   = 256;
    localparam int DATA_WIDTH = 32;
    localparam int POS_W      = 9;
    localparam int VAL_W      = 32;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    // One cycle's access to the list memory.
    typedef struct packed {
        logic                  we;
        logic [IDX_W-1:0]      waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic                  re;
        logic [IDX_W-1:0]      raddr;
    } mem_req_t;

endpackage

>>> rtl/pil_ram.sv
// Simple dual-port synchronous RAM with registered read.
module pil_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    parameter int AW    = 8
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data valid the cycle after the address.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/pil_ctrl.sv
// Request sequencer: range checks, shift walk over the list memory, results.
`include "positional_list_insert_delete_macros.svh"

module pil_ctrl import pil_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  req_type,
    input  logic [POS_W-1:0]      position,
    input  logic signed [VAL_W-1:0] value,
    output logic                  done,
    output logic [1:0]            status,
    output logic signed [VAL_W-1:0] removed_value,
    output logic [CNT_W-1:0]      list_length,
    output mem_req_t              mem_req,
    input  logic [DATA_WIDTH-1:0] mem_rdata
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_SHIFT = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  done_reg, done_next;
    status_t               status_reg, status_next;
    logic [VAL_W-1:0]      removed_reg, removed_next;
    logic                  ins_reg, ins_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic [IDX_W-1:0]      ptr_reg, ptr_next;
    logic [IDX_W-1:0]      last_reg, last_next;
    logic [IDX_W-1:0]      slot_reg, slot_next;
    logic [DATA_WIDTH-1:0] value_reg, value_next;
    logic                  pend_reg, pend_next;
    logic                  first_reg, first_next;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] pos_m1;
    logic [CMP_W-1:0] cnt_m1;
    logic [CMP_W-1:0] span;
    logic             range_ok;
    logic             list_full;
    logic             req_ok;
    logic             accept;

    // Range and capacity checks on the incoming request.
    always_comb
    begin
        pos_ext   = CMP_W'(position);
        cnt_ext   = CMP_W'(count_reg);
        pos_m1    = pos_ext - CMP_W'(1);
        cnt_m1    = cnt_ext - CMP_W'(1);
        span      = cnt_ext - pos_ext + CMP_W'(1);
        list_full = (count_reg == CNT_W'(CAPACITY));
        if (req_type == REQ_INSERT)
        begin
            range_ok = (position != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
            req_ok   = range_ok && !list_full;
        end
        else
        begin
            range_ok = (position != '0) && (pos_ext <= cnt_ext);
            req_ok   = range_ok;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // Next-state logic. Reads and writes in the shift walk always target
    // distinct entries two apart, so no forwarding is needed.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        removed_next = removed_reg;
        ins_next     = ins_reg;
        rem_next     = rem_reg;
        ptr_next     = ptr_reg;
        last_next    = last_reg;
        slot_next    = slot_reg;
        value_next   = value_reg;
        pend_next    = pend_reg;
        first_next   = first_reg;
        mem_req      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (!req_ok)
                    begin
                        status_next  = range_ok ? ST_FULL : ST_BADPOS;
                        removed_next = '0;
                        done_next    = 1'b1;
                    end
                    else
                    begin
                        ins_next   = (req_type == REQ_INSERT);
                        rem_next   = span[CNT_W-1:0];
                        ptr_next   = (req_type == REQ_INSERT) ? cnt_m1[IDX_W-1:0]
                                                              : pos_m1[IDX_W-1:0];
                        slot_next  = pos_m1[IDX_W-1:0];
                        value_next = DATA_WIDTH'(value);
                        pend_next  = 1'b0;
                        first_next = 1'b1;
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                // Consume the word read in the previous cycle.
                if (pend_reg)
                begin
                    first_next = 1'b0;
                    if (ins_reg)
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = last_reg + IDX_W'(1);
                        mem_req.wdata = mem_rdata;
                    end
                    else if (first_reg)
                    begin
                        removed_next = VAL_W'(signed'(mem_rdata));
                    end
                    else
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = last_reg - IDX_W'(1);
                        mem_req.wdata = mem_rdata;
                    end
                end

                // Issue the next read of the walk, or close the request.
                if (rem_reg != '0)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ptr_reg;
                    last_next     = ptr_reg;
                    pend_next     = 1'b1;
                    rem_next      = rem_reg - CNT_W'(1);
                    ptr_next      = ins_reg ? ptr_reg - IDX_W'(1) : ptr_reg + IDX_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (ins_reg)
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = slot_reg;
                            mem_req.wdata = value_reg;
                            removed_next  = '0;
                            count_next    = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                        status_next = ST_OK;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            pend_reg  <= pend_next;
            rem_reg   <= rem_next;
        end
    end

    // Payload and walk registers.
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        removed_reg <= removed_next;
        ins_reg     <= ins_next;
        ptr_reg     <= ptr_next;
        last_reg    <= last_next;
        slot_reg    <= slot_next;
        value_reg   <= value_next;
        first_reg   <= first_next;
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign removed_value = signed'(removed_reg);
    assign list_length   = count_reg;

    // The length never runs past the capacity.
    `PIL_ASSERT_NOW(a_count_cap, 1'b1, count_reg <= CNT_W'(CAPACITY))
    // A refused request answers on the next cycle with a failure status.
    `PIL_ASSERT_NEXT(a_refused_fast, accept && !req_ok, done_reg && status_reg != ST_OK)
    // Reads and writes of the same cycle never hit the same entry.
    `PIL_ASSERT_NOW(a_no_overlap, mem_req.we && mem_req.re, mem_req.waddr != mem_req.raddr)
    // A full status is only given when the list is at capacity.
    `PIL_ASSERT_NOW(a_full_status, done_reg && status_reg == ST_FULL,
                    count_reg == CNT_W'(CAPACITY))
    // A result never appears while a walk is still in progress.
    `PIL_ASSERT_NOW(a_done_idle, done_reg, state_reg == S_IDLE)

endmodule

>>> rtl/positional_list_insert_delete.sv
// Top level of the positional list: sequencer and list memory.
//
// Usage: raise start with req_type, position and value; the request is
// taken at a rising edge where start is high and busy is low. req_type 0
// inserts value at the 1-based position, 1 deletes the entry there.
// Each request gives exactly one result: done is high for one cycle with
// status, removed_value and list_length on their ports for that cycle.
// The receiver cannot stall; it must take the result when done is high.
// A refused request (bad position or full list) answers in the cycle after
// it is taken and busy stays low. An accepted request walks the list
// memory one entry a cycle, limited by its single read and single write
// port, reading n = length - position + 1 entries. busy is high during
// the walk and a new request may be taken in the cycle of done.
// Reset clears the length to zero and the sequencer to idle; the memory
// contents are not cleared, as only entries below the length are read.
module positional_list_insert_delete import pil_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    req_type,
    input  logic [POS_W-1:0]        position,
    input  logic signed [VAL_W-1:0] value,
    output logic                    done,
    output logic [1:0]              status,
    output logic signed [VAL_W-1:0] removed_value,
    output logic [CNT_W-1:0]        list_length
);

    mem_req_t              mem_req;
    logic [DATA_WIDTH-1:0] mem_rdata;

    // Request sequencing and result registers.
    pil_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .position      (position),
        .value         (value),
        .done          (done),
        .status        (status),
        .removed_value (removed_value),
        .list_length   (list_length),
        .mem_req       (mem_req),
        .mem_rdata     (mem_rdata)
    );

    // List storage.
    pil_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

endmodule
